// ----- hw/rtl/jmsw_pkg.sv -----
// Shared types, constants and the marker classifier for the JPEG marker segment walker.
// Has no dependencies; every other file in hw/rtl imports it.
`default_nettype none

package jmsw_pkg;

  // Marker prefix and marker codes
  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] CODE_SOI      = 8'hD8;
  localparam logic [7:0] CODE_EOI      = 8'hD9;
  localparam logic [7:0] CODE_APP0     = 8'hE0;
  localparam logic [7:0] CODE_DQT      = 8'hDB;
  localparam logic [7:0] CODE_DHT      = 8'hC4;
  localparam logic [7:0] CODE_SOF0     = 8'hC0;
  localparam logic [7:0] CODE_SOF1     = 8'hC1;
  localparam logic [7:0] CODE_SOF2     = 8'hC2;
  localparam logic [7:0] CODE_SOS      = 8'hDA;

  // Segment length counts its own two bytes
  localparam logic [15:0] LENGTH_BYTES = 16'd2;

  // Event kinds reported on the result stream
  localparam logic [1:0] EV_MARKER  = 2'd0;
  localparam logic [1:0] EV_LENGTH  = 2'd1;
  localparam logic [1:0] EV_MISSING = 2'd2;

  // Marker kinds
  localparam logic [3:0] MK_SOI     = 4'd0;
  localparam logic [3:0] MK_EOI     = 4'd1;
  localparam logic [3:0] MK_JFIF    = 4'd2;
  localparam logic [3:0] MK_DQT     = 4'd3;
  localparam logic [3:0] MK_DHT     = 4'd4;
  localparam logic [3:0] MK_SOF0    = 4'd5;
  localparam logic [3:0] MK_SOF1    = 4'd6;
  localparam logic [3:0] MK_SOF2    = 4'd7;
  localparam logic [3:0] MK_SOS     = 4'd8;
  localparam logic [3:0] MK_UNKNOWN = 4'd9;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_MARK = 3'd0,
    PH_CODE = 3'd1,
    PH_LENH = 3'd2,
    PH_LENL = 3'd3,
    PH_SKIP = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  // One result beat, event_kind in the lowest bits
  typedef struct packed {
    logic [15:0] segment_length;
    logic [7:0]  marker_code;
    logic [3:0]  marker_kind;
    logic [1:0]  event_kind;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // Map a marker code to its kind
  function automatic logic [3:0] classify(input logic [7:0] code);
    logic [3:0] kind;
    case (code)
      CODE_SOI:  kind = MK_SOI;
      CODE_EOI:  kind = MK_EOI;
      CODE_APP0: kind = MK_JFIF;
      CODE_DQT:  kind = MK_DQT;
      CODE_DHT:  kind = MK_DHT;
      CODE_SOF0: kind = MK_SOF0;
      CODE_SOF1: kind = MK_SOF1;
      CODE_SOF2: kind = MK_SOF2;
      CODE_SOS:  kind = MK_SOS;
      default:   kind = MK_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jmsw_parser.sv -----
// Phase state machine of the marker segment walker: consumes one byte per step
// and produces at most one result. Depends on jmsw_pkg.
`default_nettype none

module jmsw_parser
  import jmsw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  output logic            emit,
  output result_t         result
);

  phase_t      phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [15:0] seg_len;
  logic [3:0]  kind;

  assign seg_len = {length_high, in_byte};
  assign kind    = classify(in_byte);

  // Hold state unless a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MARK;
      length_high    <= '0;
      skip_remaining <= '0;
    end else if (step) begin
      phase          <= phase_next;
      length_high    <= length_high_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  // Next phase and result for the current byte
  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    skip_remaining_next = skip_remaining;
    emit                = 1'b0;
    result              = '0;
    case (phase)
      PH_MARK: begin
        if (in_byte != MARKER_PREFIX) begin
          emit               = 1'b1;
          result.event_kind  = EV_MISSING;
          result.marker_kind = MK_UNKNOWN;
          result.marker_code = in_byte;
          phase_next         = PH_HALT;
        end else begin
          phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        emit               = 1'b1;
        result.event_kind  = EV_MARKER;
        result.marker_kind = kind;
        result.marker_code = in_byte;
        if (kind == MK_SOS) begin
          phase_next = PH_HALT;
        end else if (kind == MK_SOI || kind == MK_EOI) begin
          phase_next = PH_MARK;
        end else begin
          phase_next = PH_LENH;
        end
      end
      PH_LENH: begin
        length_high_next = in_byte;
        phase_next       = PH_LENL;
      end
      PH_LENL: begin
        emit                  = 1'b1;
        result.event_kind     = EV_LENGTH;
        result.segment_length = seg_len;
        if (seg_len > LENGTH_BYTES) begin
          skip_remaining_next = seg_len - LENGTH_BYTES;
          phase_next          = PH_SKIP;
        end else begin
          skip_remaining_next = '0;
          phase_next          = PH_MARK;
        end
      end
      PH_SKIP: begin
        // Drop payload bytes; the last one returns to marker position
        if (skip_remaining != '0) begin
          skip_remaining_next = skip_remaining - 16'd1;
        end
        if (skip_remaining <= 16'd1) begin
          phase_next = PH_MARK;
        end
      end
      default: begin
        // Halted: ignore every byte until reset
        phase_next = phase;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jmsw_out_reg.sv -----
// Result register of the marker segment walker, holding one beat for the
// downstream stream. Depends on jmsw_pkg.
`default_nettype none

module jmsw_out_reg
  import jmsw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire result_t  load_data,
  output logic          can_load,
  output logic          out_valid,
  input  wire logic     out_ready,
  output result_t       out_data
);

  assign can_load = !out_valid || out_ready;

  // Valid flag: set on load, clear once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: capture only on load
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jpeg_marker_segment_walker_core.sv -----
// Top level of the JPEG marker segment walker: input register, parser and
// result register. Depends on jmsw_pkg, jmsw_parser and jmsw_out_reg.
`default_nettype none

// Walks the marker segments of a JPEG byte stream at one byte per clock cycle
// sustained. Each accepted byte sits in an input register, where the phase
// state machine classifies it and updates its state when the byte is consumed;
// a marker, a segment length or a missing-marker error is then loaded into the
// result register, which offers it on the output. The event kind travels on
// m_tuser, the marker and length fields on m_tdata. Payload bytes of each
// segment are consumed without a result. After a start-of-scan marker or a
// missing 0xFF the block keeps accepting bytes but reports nothing more until
// reset. A held result stalls input only when the byte in the input register
// would produce another result.
module jpeg_marker_segment_walker_core
  import jmsw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [3:0] marker_kind, [11:4] marker_code,
                                                // [27:12] segment_length, [31:28] zero
  output logic [OUT_USER_W-1:0]      m_tuser    // [1:0] event_kind
);

  logic                 in_valid;
  logic [IN_DATA_W-1:0] in_byte;
  logic                 emit;
  logic                 can_load;
  logic                 step;
  result_t              result;
  result_t              out_data;

  // Consume the held byte unless its result cannot be stored
  assign step     = in_valid && (!emit || can_load);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  jmsw_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .emit    (emit),
    .result  (result)
  );

  jmsw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  // Split the held beat into its kind and its marker and length fields
  assign m_tuser = out_data.event_kind;
  assign m_tdata = {{(OUT_DATA_W - RESULT_W + OUT_USER_W){1'b0}},
                    out_data.segment_length, out_data.marker_code, out_data.marker_kind};

endmodule

`default_nettype wire

// ----- hw/rtl/jmsw_checker.sv -----
// Port-level checks on the result stream of the marker segment walker, and
// the bind that attaches them to the top level. Depends on jmsw_pkg.
`default_nettype none

module jmsw_checker
  import jmsw_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [OUT_USER_W-1:0] m_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A marker beat carries no length
  a_marker_no_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_MARKER |-> m_tdata[27:12] == 16'd0)
    else $error("marker beat with nonzero length");

  // A length beat carries no marker
  a_length_no_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_LENGTH |-> m_tdata[11:0] == 12'd0)
    else $error("length beat with marker fields set");

  // A missing marker is reported as unknown, with no length
  a_missing_unknown: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_MISSING
      |-> m_tdata[3:0] == MK_UNKNOWN && m_tdata[27:12] == 16'd0)
    else $error("missing-marker beat malformed");

  // Event kind and padding stay in range
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= EV_MISSING && m_tdata[31:28] == 4'd0)
    else $error("result beat with bad event kind or padding");

endmodule

bind jpeg_marker_segment_walker_core jmsw_checker u_jmsw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- test/tb_jpeg_marker_segment_walker_core.sv -----
// Testbench for jpeg_marker_segment_walker_core: directed byte table, then random segments.
// Predicts every marker, length and missing-marker event locally. Depends on jmsw_pkg.
`default_nettype none

module tb_jpeg_marker_segment_walker_core;
  import jmsw_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int RANDOM_BYTES = 650;
  localparam int HOLD_AT      = 400;   // random byte count that starts the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_ROWS     = 26;

  // Known marker codes, indexed by their marker kind
  localparam logic [8:0][7:0] KNOWN_CODES = {CODE_SOS, CODE_SOF2, CODE_SOF1, CODE_SOF0,
                                             CODE_DHT, CODE_DQT, CODE_APP0, CODE_EOI,
                                             CODE_SOI};

  // One directed row: a byte sent reps times, with an optional typed-in event
  typedef struct packed {
    logic [7:0]  data;
    logic [16:0] reps;
    logic        typed;
    result_t     ev;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // Walker state as predicted
  phase_t      walk_phase = PH_MARK;
  logic [7:0]  len_high_q = '0;
  logic [15:0] skip_left  = '0;

  result_t     pending_events[$];
  stim_row_t   directed_rows[NUM_ROWS];
  int          errors = 0;
  int          events_seen = 0;
  int          random_fed = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          steady = 1'b0;

  jpeg_marker_segment_walker_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Look up the marker kind of a code byte
  function automatic logic [3:0] marker_kind_of(input logic [7:0] code);
    logic [3:0] kind;
    kind = MK_UNKNOWN;
    for (int i = 0; i < 9; i++) begin
      if (KNOWN_CODES[i] == code) kind = 4'(i);
    end
    return kind;
  endfunction

  // Advance the predicted walker by one byte; flag and return any event it causes
  task automatic advance_walker(input logic [7:0] b, output logic has_ev, output result_t ev);
    logic [3:0]  kind;
    logic [15:0] seg_len;
    has_ev = 1'b0;
    ev = '0;
    case (walk_phase)
      PH_MARK: begin
        if (b != MARKER_PREFIX) begin
          has_ev = 1'b1;
          ev.event_kind  = EV_MISSING;
          ev.marker_kind = MK_UNKNOWN;
          ev.marker_code = b;
          walk_phase = PH_HALT;
        end else begin
          walk_phase = PH_CODE;
        end
      end
      PH_CODE: begin
        kind = marker_kind_of(b);
        has_ev = 1'b1;
        ev.event_kind  = EV_MARKER;
        ev.marker_kind = kind;
        ev.marker_code = b;
        if (kind == MK_SOS) walk_phase = PH_HALT;
        else if (kind == MK_SOI || kind == MK_EOI) walk_phase = PH_MARK;
        else walk_phase = PH_LENH;
      end
      PH_LENH: begin
        len_high_q = b;
        walk_phase = PH_LENL;
      end
      PH_LENL: begin
        seg_len = {len_high_q, b};
        has_ev = 1'b1;
        ev.event_kind     = EV_LENGTH;
        ev.segment_length = seg_len;
        if (seg_len > LENGTH_BYTES) begin
          skip_left  = seg_len - LENGTH_BYTES;
          walk_phase = PH_SKIP;
        end else begin
          skip_left  = '0;
          walk_phase = PH_MARK;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 16'd1;
        if (skip_left == 0) walk_phase = PH_MARK;
      end
      default: ;
    endcase
  endtask

  // Offer one byte, hold it until accepted, then queue the event it causes
  task automatic feed_byte(input logic [7:0] b, input logic use_typed, input result_t typed_ev);
    logic    has_ev;
    result_t ev;
    while (!steady && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    advance_walker(b, has_ev, ev);
    if (has_ev) pending_events.push_back(use_typed ? typed_ev : ev);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    errors++;
    if (errors <= 40)
      $display("mismatch on %s at event %0d: got %0h, want %0h", what, events_seen,
               got_v, want_v);
  endtask

  // Check each result beat against the oldest predicted event
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'({m_tdata[RESULT_W-OUT_USER_W-1:0], m_tuser});
      if (m_tdata[OUT_DATA_W-1:RESULT_W-OUT_USER_W] != '0)
        report_mismatch("padding", m_tdata, '0);
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, '0);
      end else begin
        want = pending_events.pop_front();
        if (got.event_kind != want.event_kind)
          report_mismatch("event_kind", got.event_kind, want.event_kind);
        if (got.marker_kind != want.marker_kind)
          report_mismatch("marker_kind", got.marker_kind, want.marker_kind);
        if (got.marker_code != want.marker_code)
          report_mismatch("marker_code", got.marker_code, want.marker_code);
        if (got.segment_length != want.segment_length)
          report_mismatch("segment_length", got.segment_length, want.segment_length);
      end
      events_seen++;
    end
  end

  // Drive the receiver: random stalls, one long hold-off to back up the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && random_fed >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  code;
    logic [15:0] seg_len;
    logic [15:0] payload;
    int          pick;

    // Directed walk: SOI, EOI, APP0, DQT, DHT, SOF0 and an unknown marker, short lengths, repeated 0xFF
    directed_rows = '{
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_SOI, 17'd1, 1'b1, {16'd0, CODE_SOI, MK_SOI, EV_MARKER}},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_EOI, 17'd1, 1'b1, {16'd0, CODE_EOI, MK_EOI, EV_MARKER}},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_APP0, 17'd1, 1'b1, {16'd0, CODE_APP0, MK_JFIF, EV_MARKER}},
      '{8'h00, 17'd1, 1'b0, '0},
      '{8'h02, 17'd1, 1'b1, {16'd2, 8'd0, 4'd0, EV_LENGTH}},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_DQT, 17'd1, 1'b1, {16'd0, CODE_DQT, MK_DQT, EV_MARKER}},
      '{8'h00, 17'd1, 1'b0, '0},
      '{8'h00, 17'd1, 1'b1, {16'd0, 8'd0, 4'd0, EV_LENGTH}},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_DHT, 17'd1, 1'b1, {16'd0, CODE_DHT, MK_DHT, EV_MARKER}},
      '{8'h00, 17'd1, 1'b0, '0},
      '{8'h01, 17'd1, 1'b1, {16'd1, 8'd0, 4'd0, EV_LENGTH}},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{CODE_SOF0, 17'd1, 1'b1, {16'd0, CODE_SOF0, MK_SOF0, EV_MARKER}},
      '{8'h00, 17'd1, 1'b0, '0},
      '{8'h03, 17'd1, 1'b0, '0},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{8'hFF, 17'd1, 1'b0, '0},
      '{8'hFF, 17'd1, 1'b1, {16'd0, 8'hFF, MK_UNKNOWN, EV_MARKER}},
      '{8'h00, 17'd1, 1'b0, '0},
      '{8'h04, 17'd1, 1'b1, {16'd4, 8'd0, 4'd0, EV_LENGTH}},
      '{8'hFF, 17'd2, 1'b0, '0}
    };

    // Hold reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int n = 0; n < directed_rows[i].reps; n++)
        feed_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].ev);
    end

    // Random segments, some with lengths below two; a stretch in the middle runs without idling
    while (random_fed < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) code = $urandom_range(0, 1) ? CODE_SOI : CODE_EOI;
      else if (pick < 70) code = KNOWN_CODES[$urandom_range(2, 7)];
      else if (pick < 80) code = MARKER_PREFIX;
      else begin
        code = 8'($urandom);
        if (code == CODE_SOS) code = CODE_DQT;
      end
      feed_byte(MARKER_PREFIX, 1'b0, '0);
      feed_byte(code, 1'b0, '0);
      random_fed += 2;
      if (marker_kind_of(code) != MK_SOI && marker_kind_of(code) != MK_EOI) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) seg_len = 16'($urandom_range(0, 2));
        else if (pick < 90) seg_len = 16'($urandom_range(3, 12));
        else seg_len = 16'($urandom_range(13, 100));
        feed_byte(seg_len[15:8], 1'b0, '0);
        feed_byte(seg_len[7:0], 1'b0, '0);
        random_fed += 2;
        payload = (seg_len > LENGTH_BYTES) ? seg_len - LENGTH_BYTES : 16'd0;
        for (int n = 0; n < payload; n++) begin
          feed_byte(($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom), 1'b0, '0);
          random_fed++;
        end
      end
      steady = (random_fed >= 150 && random_fed < 330);
    end
    steady = 1'b0;

    // Close with a start of scan, a missing marker byte or the longest segment
    // length; the bytes after it are dropped or skipped
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      feed_byte(MARKER_PREFIX, 1'b0, '0);
      feed_byte(CODE_SOS, 1'b0, '0);
    end else if (pick == 1) begin
      feed_byte(8'($urandom_range(0, 254)), 1'b0, '0);
    end else begin
      repeat (4) feed_byte(MARKER_PREFIX, 1'b0, '0);
    end
    repeat (6) feed_byte(8'($urandom), 1'b0, '0);
    s_tvalid <= 1'b0;

    wait (pending_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
